### src/mlqs_pkg.sv
// Shared types and constants of the multilevel queue slot scheduler.
// Depends on nothing; the files that use it refer to it by scoped names.
package mlqs_pkg;

    localparam int NUM_QUEUES_DEF  = 11;
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int SLOT_DEPTH_DEF  = 128;

    localparam int QN_W   = 4;
    localparam int ID_W   = 16;
    localparam int QT_W   = 10;
    localparam int SIDX_W = 7;
    localparam int SC_W   = 8;

    localparam logic [SC_W-1:0] SLOT_COUNT_RST = 8'd100;

    typedef enum logic [1:0] {
        CMD_LOAD = 2'd0,
        CMD_ENQ  = 2'd1,
        CMD_TICK = 2'd2,
        CMD_BAD  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_DROP = 2'd1,
        ST_IDLE = 2'd2,
        ST_BAD  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        OP_REPORT = 2'd0,
        OP_ENQ    = 2'd1,
        OP_TICK   = 2'd2
    } op_kind_t;

    // One classified command handed from the front end to the back end.
    typedef struct packed {
        op_kind_t          kind;
        status_t           status;
        logic [QN_W-1:0]   queue;
        logic [ID_W-1:0]   id;
        logic [QT_W-1:0]   quanta;
    } op_t;

endpackage

### src/multilevel_queue_slot_scheduler.sv
// Top level of the multilevel queue slot scheduler: APB register, front end,
// command queue and back end. Depends on mlqs_pkg, mlqs_front, mlqs_opq, mlqs_back.
//
// The block runs one command at a time. A command is taken when start is high
// and busy is low; busy then stays high until the result beat has been shown on
// the result ports for its single cycle, marked by done. The receiver cannot hold
// a result off, so it must take every beat in the cycle done is high. A tick that
// serves a task passes through the registered read of the slot table and then
// the registered read of the task memory, while an idle tick reads no task entry.
// busy is low again in the cycle after the done cycle, so the next command can
// be taken there. The slot table reads as queue zero until a slot is loaded.
// slot_count sits at byte address 0 of the APB port; the user must see that it is
// written only while busy is low, as the block itself does not enforce this.
module multilevel_queue_slot_scheduler #(
    parameter int NUM_QUEUES  = mlqs_pkg::NUM_QUEUES_DEF,
    parameter int QUEUE_DEPTH = mlqs_pkg::QUEUE_DEPTH_DEF,
    parameter int SLOT_DEPTH  = mlqs_pkg::SLOT_DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [2:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  cmd,
    input  logic [mlqs_pkg::SIDX_W-1:0] slot_index,
    input  logic [mlqs_pkg::QN_W-1:0]   queue_number,
    input  logic [mlqs_pkg::ID_W-1:0]   task_id,
    input  logic [mlqs_pkg::QT_W-1:0]   run_quanta,
    output logic                        done,
    output logic [1:0]                  status,
    output logic [mlqs_pkg::ID_W-1:0]   served_id,
    output logic [mlqs_pkg::QN_W-1:0]   served_queue,
    output logic [mlqs_pkg::QT_W-1:0]   quanta_left,
    output logic                        finished,
    output logic [mlqs_pkg::QN_W-1:0]   moved_to_queue
);

    logic [mlqs_pkg::SC_W-1:0] slot_count_reg;
    logic                      busy_reg, busy_next;
    logic                      accept;
    logic                      op_push, op_pop, op_empty;
    mlqs_pkg::op_t             op_in, op_out;

    // Only the first word holds a register; the word above it ignores writes.
    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : 32'(slot_count_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_count_reg <= mlqs_pkg::SLOT_COUNT_RST;
        end
        else if (psel && penable && pwrite && !paddr[2])
        begin
            slot_count_reg <= pwdata[mlqs_pkg::SC_W-1:0];
        end
    end

    // Busy covers a command from its acceptance to the end of its result beat.
    assign accept = start && !busy_reg;

    always_comb
    begin
        busy_next = busy_reg;
        if (accept)
        begin
            busy_next = 1'b1;
        end
        else if (done)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    assign busy = busy_reg;

    mlqs_front #(
        .NUM_QUEUES (NUM_QUEUES),
        .SLOT_DEPTH (SLOT_DEPTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .cmd          (cmd),
        .slot_index   (slot_index),
        .queue_number (queue_number),
        .task_id      (task_id),
        .run_quanta   (run_quanta),
        .slot_count   (slot_count_reg),
        .op_push      (op_push),
        .op_data      (op_in)
    );

    mlqs_opq u_opq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (op_push),
        .din   (op_in),
        .pop   (op_pop),
        .dout  (op_out),
        .empty (op_empty)
    );

    mlqs_back #(
        .NUM_QUEUES  (NUM_QUEUES),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .op_valid       (!op_empty),
        .op             (op_out),
        .op_pop         (op_pop),
        .done           (done),
        .status         (status),
        .served_id      (served_id),
        .served_queue   (served_queue),
        .quanta_left    (quanta_left),
        .finished       (finished),
        .moved_to_queue (moved_to_queue)
    );

endmodule

### src/mlqs_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module mlqs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### src/mlqs_front.sv
// Front end: accepts commands, checks them, owns the slot table and slot pointer.
// Depends on mlqs_pkg and mlqs_ram.
module mlqs_front #(
    parameter int NUM_QUEUES = mlqs_pkg::NUM_QUEUES_DEF,
    parameter int SLOT_DEPTH = mlqs_pkg::SLOT_DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        accept,
    input  logic [1:0]                  cmd,
    input  logic [mlqs_pkg::SIDX_W-1:0] slot_index,
    input  logic [mlqs_pkg::QN_W-1:0]   queue_number,
    input  logic [mlqs_pkg::ID_W-1:0]   task_id,
    input  logic [mlqs_pkg::QT_W-1:0]   run_quanta,
    input  logic [mlqs_pkg::SC_W-1:0]   slot_count,
    output logic                        op_push,
    output mlqs_pkg::op_t               op_data
);

    localparam int SW = $clog2(SLOT_DEPTH);
    localparam int CW = (SW + 1 > mlqs_pkg::SC_W) ? SW + 1 : mlqs_pkg::SC_W;

    typedef enum logic {F_IDLE, F_READ} fstate_t;

    fstate_t                 state_reg, state_next;
    logic [SW-1:0]           ptr_reg, ptr_next;
    logic [SLOT_DEPTH-1:0]   valid_reg, valid_next;
    logic                    rdvld_reg, rdvld_next;

    logic [CW-1:0]           cnt;
    logic [SW-1:0]           ptr_use;
    logic [CW-1:0]           ptr_inc;
    logic [SW-1:0]           slot_addr;
    logic                    idx_ok, qn_ok, load_we;
    logic [mlqs_pkg::QN_W-1:0] slot_rdata;

    always_comb
    begin
        cnt = CW'(slot_count);
        if (cnt == '0)
        begin
            cnt = CW'(1);
        end
        if (int'(cnt) > SLOT_DEPTH)
        begin
            cnt = CW'(SLOT_DEPTH);
        end
    end

    // A pointer left beyond a lowered count restarts at slot zero.
    assign ptr_use   = (CW'(ptr_reg) >= cnt) ? '0 : ptr_reg;
    assign ptr_inc   = CW'(ptr_use) + CW'(1);
    assign slot_addr = SW'(slot_index);
    assign idx_ok    = int'(slot_index) < SLOT_DEPTH;
    assign qn_ok     = int'(queue_number) < NUM_QUEUES;
    assign load_we   = accept && (cmd == mlqs_pkg::CMD_LOAD) && idx_ok && qn_ok;

    mlqs_ram #(
        .WIDTH (mlqs_pkg::QN_W),
        .DEPTH (SLOT_DEPTH)
    ) u_slot_ram (
        .clk   (clk),
        .we    (load_we),
        .waddr (slot_addr),
        .wdata (queue_number),
        .raddr (ptr_use),
        .rdata (slot_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        ptr_next       = ptr_reg;
        valid_next     = valid_reg;
        rdvld_next     = rdvld_reg;
        op_push        = 1'b0;
        op_data.kind   = mlqs_pkg::OP_REPORT;
        op_data.status = mlqs_pkg::ST_OK;
        op_data.queue  = queue_number;
        op_data.id     = task_id;
        op_data.quanta = (run_quanta == '0) ? mlqs_pkg::QT_W'(1) : run_quanta;
        if (load_we)
        begin
            valid_next[slot_addr] = 1'b1;
        end
        unique case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd)
                        mlqs_pkg::CMD_LOAD:
                        begin
                            op_push        = 1'b1;
                            op_data.status = (idx_ok && qn_ok) ? mlqs_pkg::ST_OK
                                                               : mlqs_pkg::ST_BAD;
                        end
                        mlqs_pkg::CMD_ENQ:
                        begin
                            op_push = 1'b1;
                            if (qn_ok)
                            begin
                                op_data.kind = mlqs_pkg::OP_ENQ;
                            end
                            else
                            begin
                                op_data.status = mlqs_pkg::ST_BAD;
                            end
                        end
                        mlqs_pkg::CMD_TICK:
                        begin
                            state_next = F_READ;
                            rdvld_next = valid_reg[ptr_use];
                            ptr_next   = (ptr_inc >= cnt) ? '0 : ptr_inc[SW-1:0];
                        end
                        default:
                        begin
                            op_push        = 1'b1;
                            op_data.status = mlqs_pkg::ST_BAD;
                        end
                    endcase
                end
            end
            F_READ:
            begin
                // Slot read data is back; a never-loaded slot names queue zero.
                op_push      = 1'b1;
                op_data.kind = mlqs_pkg::OP_TICK;
                op_data.queue = rdvld_reg ? slot_rdata : '0;
                state_next   = F_IDLE;
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            ptr_reg   <= '0;
            valid_reg <= '0;
            rdvld_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ptr_reg   <= ptr_next;
            valid_reg <= valid_next;
            rdvld_reg <= rdvld_next;
        end
    end

endmodule

### src/mlqs_opq.sv
// Two-entry queue of classified commands between the front and back ends.
// Depends on mlqs_pkg.
module mlqs_opq (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  mlqs_pkg::op_t din,
    input  logic          pop,
    output mlqs_pkg::op_t dout,
    output logic          empty
);

    mlqs_pkg::op_t ent_reg [2];
    logic          wr_reg, rd_reg;
    logic [1:0]    cnt_reg;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= ~wr_reg;
            end
            if (pop)
            begin
                rd_reg <= ~rd_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    assign dout  = ent_reg[rd_reg];
    assign empty = (cnt_reg == '0);

endmodule

### src/mlqs_back.sv
// Back end: task queues, cyclic search for a non-empty queue, serve and re-append.
// Depends on mlqs_pkg and mlqs_ram.
module mlqs_back #(
    parameter int NUM_QUEUES  = mlqs_pkg::NUM_QUEUES_DEF,
    parameter int QUEUE_DEPTH = mlqs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      op_valid,
    input  mlqs_pkg::op_t             op,
    output logic                      op_pop,
    output logic                      done,
    output logic [1:0]                status,
    output logic [mlqs_pkg::ID_W-1:0] served_id,
    output logic [mlqs_pkg::QN_W-1:0] served_queue,
    output logic [mlqs_pkg::QT_W-1:0] quanta_left,
    output logic                      finished,
    output logic [mlqs_pkg::QN_W-1:0] moved_to_queue
);

    localparam int HW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FW = $clog2(QUEUE_DEPTH + 1);
    localparam int MD = NUM_QUEUES * QUEUE_DEPTH;
    localparam int AW = (MD > 1) ? $clog2(MD) : 1;
    localparam int EW = mlqs_pkg::ID_W + mlqs_pkg::QT_W;
    localparam int QW = mlqs_pkg::QN_W;

    typedef enum logic {B_IDLE, B_SERVE} bstate_t;

    bstate_t              state_reg, state_next;
    logic [HW-1:0]        head_reg [NUM_QUEUES];
    logic [HW-1:0]        head_next [NUM_QUEUES];
    logic [FW-1:0]        fill_reg [NUM_QUEUES];
    logic [FW-1:0]        fill_next [NUM_QUEUES];
    logic [QW-1:0]        cur_reg, cur_next;

    logic                 done_reg, done_next;
    mlqs_pkg::status_t    status_reg, status_next;
    logic [mlqs_pkg::ID_W-1:0] sid_reg, sid_next;
    logic [QW-1:0]        sq_reg, sq_next;
    logic [mlqs_pkg::QT_W-1:0] left_reg, left_next;
    logic                 fin_reg, fin_next;
    logic [QW-1:0]        moved_reg, moved_next;

    logic                 we;
    logic [AW-1:0]        waddr, raddr;
    logic [EW-1:0]        wdata, rdata;

    logic                 found;
    logic [QW-1:0]        fq;
    logic [mlqs_pkg::QT_W-1:0] qt;
    logic [QW-1:0]        nq;
    int                   c;

    function automatic logic [AW-1:0] slot_addr(input logic [QW-1:0] q,
                                                 input logic [HW-1:0] pos);
        slot_addr = AW'(int'(q) * QUEUE_DEPTH + int'(pos));
    endfunction

    function automatic logic [HW-1:0] tail_pos(input logic [HW-1:0] h,
                                               input logic [FW-1:0] f);
        logic [FW:0] s;
        s = (FW + 1)'(h) + (FW + 1)'(f);
        if (int'(s) >= QUEUE_DEPTH)
        begin
            s = s - (FW + 1)'(QUEUE_DEPTH);
        end
        tail_pos = HW'(s);
    endfunction

    mlqs_ram #(
        .WIDTH (EW),
        .DEPTH (MD)
    ) u_task_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // First non-empty queue at or after the start queue, wrapping around.
    always_comb
    begin
        found = 1'b0;
        fq    = '0;
        for (int i = 0; i < NUM_QUEUES; i++)
        begin
            c = int'(op.queue) + i;
            if (c >= NUM_QUEUES)
            begin
                c = c - NUM_QUEUES;
            end
            if (!found && (fill_reg[c] != '0))
            begin
                found = 1'b1;
                fq    = QW'(c);
            end
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        head_next   = head_reg;
        fill_next   = fill_reg;
        cur_next    = cur_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        sid_next    = sid_reg;
        sq_next     = sq_reg;
        left_next   = left_reg;
        fin_next    = fin_reg;
        moved_next  = moved_reg;
        op_pop      = 1'b0;
        we          = 1'b0;
        waddr       = '0;
        wdata       = {op.id, op.quanta};
        raddr       = slot_addr(fq, head_reg[fq]);
        qt          = rdata[mlqs_pkg::QT_W-1:0];
        nq          = '0;
        unique case (state_reg)
            B_IDLE:
            begin
                if (op_valid)
                begin
                    op_pop      = 1'b1;
                    done_next   = 1'b1;
                    status_next = op.status;
                    sid_next    = '0;
                    sq_next     = '0;
                    left_next   = '0;
                    fin_next    = 1'b0;
                    moved_next  = '0;
                    unique case (op.kind)
                        mlqs_pkg::OP_ENQ:
                        begin
                            if (fill_reg[op.queue] == FW'(QUEUE_DEPTH))
                            begin
                                status_next = mlqs_pkg::ST_DROP;
                            end
                            else
                            begin
                                we    = 1'b1;
                                waddr = slot_addr(op.queue,
                                        tail_pos(head_reg[op.queue], fill_reg[op.queue]));
                                fill_next[op.queue] = fill_reg[op.queue] + FW'(1);
                            end
                        end
                        mlqs_pkg::OP_TICK:
                        begin
                            if (!found)
                            begin
                                status_next = mlqs_pkg::ST_IDLE;
                            end
                            else
                            begin
                                // Pop now; the entry arrives from the RAM next cycle.
                                done_next = 1'b0;
                                cur_next  = fq;
                                fill_next[fq] = fill_reg[fq] - FW'(1);
                                head_next[fq] = (int'(head_reg[fq]) + 1 == QUEUE_DEPTH)
                                              ? '0 : head_reg[fq] + HW'(1);
                                state_next = B_SERVE;
                            end
                        end
                        default:
                        begin
                            status_next = op.status;
                        end
                    endcase
                end
            end
            B_SERVE:
            begin
                done_next   = 1'b1;
                status_next = mlqs_pkg::ST_OK;
                sid_next    = rdata[EW-1:mlqs_pkg::QT_W];
                sq_next     = cur_reg;
                left_next   = (qt == '0) ? '0 : qt - mlqs_pkg::QT_W'(1);
                fin_next    = (left_next == '0);
                moved_next  = '0;
                if (!fin_next)
                begin
                    nq = (int'(cur_reg) + 1 == NUM_QUEUES) ? '0 : cur_reg + QW'(1);
                    // A full next queue sends the task back to its own tail.
                    if (fill_reg[nq] == FW'(QUEUE_DEPTH))
                    begin
                        nq = cur_reg;
                    end
                    we    = 1'b1;
                    waddr = slot_addr(nq, tail_pos(head_reg[nq], fill_reg[nq]));
                    wdata = {sid_next, left_next};
                    fill_next[nq] = fill_reg[nq] + FW'(1);
                    moved_next = nq;
                end
                state_next = B_IDLE;
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            done_reg  <= 1'b0;
            cur_reg   <= '0;
            for (int i = 0; i < NUM_QUEUES; i++)
            begin
                head_reg[i] <= '0;
                fill_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            cur_reg   <= cur_next;
            head_reg  <= head_next;
            fill_reg  <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        sid_reg    <= sid_next;
        sq_reg     <= sq_next;
        left_reg   <= left_next;
        fin_reg    <= fin_next;
        moved_reg  <= moved_next;
    end

    assign done           = done_reg;
    assign status         = status_reg;
    assign served_id      = sid_reg;
    assign served_queue   = sq_reg;
    assign quanta_left    = left_reg;
    assign finished       = fin_reg;
    assign moved_to_queue = moved_reg;

endmodule

### src/mlqs_checker.sv
// Port-level checks of the multilevel queue slot scheduler, bound to the top level.
// Depends on mlqs_pkg and multilevel_queue_slot_scheduler.
module mlqs_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      start,
    input logic                      busy,
    input logic                      done,
    input logic [1:0]                status,
    input logic [mlqs_pkg::ID_W-1:0] served_id,
    input logic                      finished,
    input logic [mlqs_pkg::QN_W-1:0] moved_to_queue
);

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted command did not raise busy");

    a_done_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result beat outside a busy command");

    a_done_frees: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy && !done)
        else $error("busy held or beat repeated after result");

    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status == mlqs_pkg::ST_IDLE) |-> (served_id == '0) && !finished)
        else $error("idle tick reported a served task");

    a_fin_nomove: assert property (@(posedge clk) disable iff (!rst_n)
        done && finished |-> (moved_to_queue == '0))
        else $error("finished task reported as moved");

endmodule

bind multilevel_queue_slot_scheduler mlqs_checker u_mlqs_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .done           (done),
    .status         (status),
    .served_id      (served_id),
    .finished       (finished),
    .moved_to_queue (moved_to_queue)
);

### test/multilevel_queue_slot_scheduler_tb.sv
// Self-checking testbench for the multilevel queue slot scheduler: directed and random
// load, enqueue and tick commands, checked beat by beat against an in-bench scheduler model.
// Depends on mlqs_pkg and the multilevel_queue_slot_scheduler top level.
module multilevel_queue_slot_scheduler_tb;

    localparam int NQ = mlqs_pkg::NUM_QUEUES_DEF;
    localparam int QD = mlqs_pkg::QUEUE_DEPTH_DEF;
    localparam int SD = mlqs_pkg::SLOT_DEPTH_DEF;
    localparam int STALL_LIMIT = 2000;

    // One command beat as the sender presents it.
    typedef struct packed {
        logic [1:0]                  cmd;
        logic [mlqs_pkg::SIDX_W-1:0] sidx;
        logic [mlqs_pkg::QN_W-1:0]   qn;
        logic [mlqs_pkg::ID_W-1:0]   id;
        logic [mlqs_pkg::QT_W-1:0]   quanta;
    } command_t;

    // One result beat.
    typedef struct packed {
        logic [1:0]                status;
        logic [mlqs_pkg::ID_W-1:0] id;
        logic [mlqs_pkg::QN_W-1:0] from_q;
        logic [mlqs_pkg::QT_W-1:0] left;
        logic                      fin;
        logic [mlqs_pkg::QN_W-1:0] moved;
    } outcome_t;

    logic                        clk;
    logic                        rst_n;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [2:0]                  paddr;
    logic [31:0]                 pwdata;
    logic [31:0]                 prdata;
    logic                        pready;
    logic                        start;
    logic                        busy;
    logic [1:0]                  cmd;
    logic [mlqs_pkg::SIDX_W-1:0] slot_index;
    logic [mlqs_pkg::QN_W-1:0]   queue_number;
    logic [mlqs_pkg::ID_W-1:0]   task_id;
    logic [mlqs_pkg::QT_W-1:0]   run_quanta;
    logic                        done;
    logic [1:0]                  status;
    logic [mlqs_pkg::ID_W-1:0]   served_id;
    logic [mlqs_pkg::QN_W-1:0]   served_queue;
    logic [mlqs_pkg::QT_W-1:0]   quanta_left;
    logic                        finished;
    logic [mlqs_pkg::QN_W-1:0]   moved_to_queue;

    multilevel_queue_slot_scheduler u_top (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .start(start), .busy(busy),
        .cmd(cmd), .slot_index(slot_index), .queue_number(queue_number),
        .task_id(task_id), .run_quanta(run_quanta),
        .done(done), .status(status), .served_id(served_id),
        .served_queue(served_queue), .quanta_left(quanta_left),
        .finished(finished), .moved_to_queue(moved_to_queue)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // Model state of the scheduler, updated as each command beat is accepted.
    logic [7:0]                mdl_slot_count;
    logic [mlqs_pkg::QN_W-1:0] mdl_slots [SD];
    logic [mlqs_pkg::ID_W-1:0] mdl_ids [NQ][QD];
    logic [mlqs_pkg::QT_W-1:0] mdl_left [NQ][QD];
    int                        mdl_head [NQ];
    int                        mdl_fill [NQ];
    int                        mdl_ptr;

    command_t pending_cmds[$];
    outcome_t awaited_outcomes[$];

    int  sender_idle_pct;
    bit  hold_sender;
    bit  failed;
    bit  took_beat;
    int  quiet_cycles;

    function automatic bit queue_append(int q, logic [mlqs_pkg::ID_W-1:0] id,
                                        logic [mlqs_pkg::QT_W-1:0] n);
        int pos;
        if (mdl_fill[q] >= QD)
            return 1'b0;
        pos = (mdl_head[q] + mdl_fill[q]) % QD;
        mdl_ids[q][pos] = id;
        mdl_left[q][pos] = n;
        mdl_fill[q]++;
        return 1'b1;
    endfunction

    // Applies one command to the model and returns the beat it must produce.
    function automatic outcome_t schedule_step(command_t c);
        outcome_t r;
        int cnt;
        int q;
        int nq;
        int i;
        bit found;
        logic [mlqs_pkg::QT_W-1:0] n;
        r = '0;
        case (mlqs_pkg::cmd_t'(c.cmd))
            mlqs_pkg::CMD_LOAD:
            begin
                if (c.qn >= NQ)
                    r.status = mlqs_pkg::ST_BAD;
                else
                    mdl_slots[c.sidx] = c.qn;
            end
            mlqs_pkg::CMD_ENQ:
            begin
                if (c.qn >= NQ)
                    r.status = mlqs_pkg::ST_BAD;
                else if (!queue_append(c.qn, c.id,
                                       (c.quanta == 0) ? mlqs_pkg::QT_W'(1) : c.quanta))
                    r.status = mlqs_pkg::ST_DROP;
            end
            mlqs_pkg::CMD_TICK:
            begin
                cnt = (mdl_slot_count == 0) ? 1 : int'(mdl_slot_count);
                if (cnt > SD)
                    cnt = SD;
                if (mdl_ptr >= cnt)
                    mdl_ptr = 0;
                q = int'(mdl_slots[mdl_ptr]) % NQ;
                found = 1'b0;
                for (i = 0; i < NQ && !found; i++)
                begin
                    if (mdl_fill[q] != 0)
                        found = 1'b1;
                    else
                        q = (q + 1) % NQ;
                end
                if (found)
                begin
                    r.id = mdl_ids[q][mdl_head[q]];
                    n = mdl_left[q][mdl_head[q]];
                    mdl_head[q] = (mdl_head[q] + 1) % QD;
                    mdl_fill[q]--;
                    r.from_q = q;
                    r.left = (n == 0) ? '0 : n - 1;
                    if (r.left == 0)
                        r.fin = 1'b1;
                    else
                    begin
                        nq = (q + 1) % NQ;
                        if (!queue_append(nq, r.id, r.left))
                        begin
                            nq = q;
                            void'(queue_append(nq, r.id, r.left));
                        end
                        r.moved = nq;
                    end
                end
                else
                    r.status = mlqs_pkg::ST_IDLE;
                mdl_ptr++;
                if (mdl_ptr >= cnt)
                    mdl_ptr = 0;
            end
            default:
                r.status = mlqs_pkg::ST_BAD;
        endcase
        return r;
    endfunction

    // Records at each rising edge whether the presented command was taken.
    always @(posedge clk)
    begin
        took_beat <= rst_n && start && !busy;
    end

    // Driver: presents the next pending command at the falling edge and holds it
    // until a rising edge at which busy is low takes it.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (took_beat)
            begin
                awaited_outcomes.push_back(schedule_step(pending_cmds.pop_front()));
                quiet_cycles = 0;
                if (pending_cmds.size() != 0 && !hold_sender
                    && $urandom_range(99, 0) >= sender_idle_pct)
                    {cmd, slot_index, queue_number, task_id, run_quanta} <= pending_cmds[0];
                else
                    start <= 1'b0;
            end
            else if (!start && pending_cmds.size() != 0 && !hold_sender
                     && $urandom_range(99, 0) >= sender_idle_pct)
            begin
                start <= 1'b1;
                {cmd, slot_index, queue_number, task_id, run_quanta} <= pending_cmds[0];
            end
        end
    end

    // Monitor: every done beat must match the oldest expected outcome.
    always @(posedge clk)
    begin
        outcome_t got;
        outcome_t want;
        if (rst_n && done)
        begin
            quiet_cycles <= 0;
            got = {status, served_id, served_queue, quanta_left, finished, moved_to_queue};
            if (awaited_outcomes.size() == 0)
            begin
                $display("%0t: unexpected result beat %h", $time, got);
                failed = 1'b1;
            end
            else
            begin
                want = awaited_outcomes.pop_front();
                if (got.status !== want.status)
                    $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
                if (got.id !== want.id)
                    $display("%0t: served_id expected %0d actual %0d", $time, want.id, got.id);
                if (got.from_q !== want.from_q)
                    $display("%0t: served_queue expected %0d actual %0d",
                             $time, want.from_q, got.from_q);
                if (got.left !== want.left)
                    $display("%0t: quanta_left expected %0d actual %0d",
                             $time, want.left, got.left);
                if (got.fin !== want.fin)
                    $display("%0t: finished expected %0d actual %0d", $time, want.fin, got.fin);
                if (got.moved !== want.moved)
                    $display("%0t: moved_to_queue expected %0d actual %0d",
                             $time, want.moved, got.moved);
                if (got !== want)
                    failed = 1'b1;
            end
        end
        else if (rst_n)
            quiet_cycles <= quiet_cycles + 1;
    end

    // Watchdog: a long stretch without any accepted beat means the block hung.
    always @(posedge clk)
    begin
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("multilevel_queue_slot_scheduler: mismatch");
            $finish;
        end
    end

    function automatic command_t make_cmd(mlqs_pkg::cmd_t op, int sidx, int qn, int id, int n);
        command_t c;
        c.cmd = op;
        c.sidx = sidx;
        c.qn = qn;
        c.id = id;
        c.quanta = n;
        return c;
    endfunction

    // Mostly valid commands, with a few bad queue numbers and bad opcodes.
    function automatic command_t random_cmd();
        int r;
        int qn;
        r = $urandom_range(99, 0);
        qn = ($urandom_range(19, 0) == 0) ? $urandom_range(15, NQ) : $urandom_range(NQ - 1, 0);
        if (r < 8)
            return make_cmd(mlqs_pkg::CMD_LOAD, $urandom_range(SD - 1, 0), qn,
                            $urandom, $urandom);
        else if (r < 45)
            return make_cmd(mlqs_pkg::CMD_ENQ, $urandom, qn, $urandom,
                            ($urandom_range(3, 0) == 0) ? $urandom : $urandom_range(4, 0));
        else if (r < 97)
            return make_cmd(mlqs_pkg::CMD_TICK, $urandom, $urandom, $urandom, $urandom);
        return make_cmd(mlqs_pkg::CMD_BAD, $urandom, $urandom, $urandom, $urandom);
    endfunction

    // Waits until the block has drained everything handed to it and the last beat has fully left.
    task automatic drain_block();
        wait (pending_cmds.size() == 0 && !start && awaited_outcomes.size() == 0);
        repeat (8) @(posedge clk);
    endtask

    // APB write of slot_count, driven on falling edges; the block is idle here.
    task automatic write_slot_count(logic [7:0] value);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= '0;
        pwdata <= {24'd0, value};
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        mdl_slot_count = value;
    endtask

    initial
    begin
        int i;
        int ph;
        logic [7:0] counts [5];
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        start = 1'b0;
        cmd = '0;
        slot_index = '0;
        queue_number = '0;
        task_id = '0;
        run_quanta = '0;
        failed = 1'b0;
        took_beat = 1'b0;
        hold_sender = 1'b0;
        sender_idle_pct = 0;
        quiet_cycles = 0;
        mdl_slot_count = mlqs_pkg::SLOT_COUNT_RST;
        mdl_ptr = 0;
        for (i = 0; i < SD; i++)
            mdl_slots[i] = '0;
        for (i = 0; i < NQ; i++)
        begin
            mdl_head[i] = 0;
            mdl_fill[i] = 0;
        end
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part at the reset slot count: idle tick, bad opcode, bad
        // queue numbers, zero quanta, field extremes, a full queue and its drop.
        pending_cmds.push_back(make_cmd(mlqs_pkg::CMD_TICK, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(mlqs_pkg::CMD_BAD, 127, 15, 16'hFFFF, 1023));
        pending_cmds.push_back(make_cmd(mlqs_pkg::CMD_LOAD, 127, 15, 0, 0));
        pending_cmds.push_back(make_cmd(mlqs_pkg::CMD_LOAD, 0, 10, 0, 0));
        pending_cmds.push_back(make_cmd(mlqs_pkg::CMD_LOAD, 127, 10, 16'hFFFF, 1023));
        pending_cmds.push_back(make_cmd(mlqs_pkg::CMD_ENQ, 0, 11, 1, 1));
        pending_cmds.push_back(make_cmd(mlqs_pkg::CMD_ENQ, 127, 10, 16'hFFFF, 0));
        pending_cmds.push_back(make_cmd(mlqs_pkg::CMD_ENQ, 0, 10, 0, 1023));
        pending_cmds.push_back(make_cmd(mlqs_pkg::CMD_TICK, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(mlqs_pkg::CMD_TICK, 0, 0, 0, 0));
        for (i = 0; i < QD + 1; i++)
            pending_cmds.push_back(make_cmd(mlqs_pkg::CMD_ENQ, 0, 3, 16'h5A00 + i, 2));
        pending_cmds.push_back(make_cmd(mlqs_pkg::CMD_LOAD, 1, 2, 0, 0));
        pending_cmds.push_back(make_cmd(mlqs_pkg::CMD_TICK, 0, 0, 0, 0));
        drain_block();

        // Random phases over several slot counts, including both extremes, zero
        // and values past the table size. The sender pauses partway once so the
        // block runs completely dry before new commands arrive.
        counts = '{8'd1, 8'd128, 8'd0, 8'd255, 8'd7};
        for (ph = 0; ph < 5; ph++)
        begin
            write_slot_count(ph == 4 ? 8'($urandom_range(128, 2)) : counts[ph]);
            sender_idle_pct = (ph % 3 == 0) ? 0 : ((ph % 3 == 1) ? 56 : 36);
            for (i = 0; i < 280; i++)
                pending_cmds.push_back(random_cmd());
            if (ph == 1)
            begin
                wait (pending_cmds.size() < 140);
                hold_sender = 1'b1;
                wait (!start && !busy && awaited_outcomes.size() == 0);
                repeat (4) @(posedge clk);
                hold_sender = 1'b0;
            end
            drain_block();
        end

        if (!failed)
            $display("multilevel_queue_slot_scheduler: match");
        else
            $display("multilevel_queue_slot_scheduler: mismatch");
        $finish;
    end
endmodule
